// ===== sv/bbd_pkg.sv =====
// Shared constants, codes and types for the Bayer bilinear demosaic block.
package bbd_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_W         = 8;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int ROW_BITS      = 12;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 11'd420;
    localparam logic [CFG_H_BITS-1:0] RST_HEIGHT = 13'd288;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // neighborhood tap modes: plain, mirrored at the start, mirrored at the end
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_LAST   = 2'd2;

    // [row][col]; row 0 oldest line, col 2 newest column
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [1:0] row_mode;
        logic [1:0] col_mode;
        logic       row_odd;
        logic       col_odd;
    } t_pix_sel;

endpackage

// ===== sv/bbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bbd_interp.sv =====
// Bilinear interpolation of one RGB pixel from the 3x3 window with edge mirroring.
module bbd_interp (
    input  bbd_pkg::t_win     i_win,
    input  bbd_pkg::t_pix_sel i_sel,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue
);
    import bbd_pkg::*;

    function automatic logic [1:0] tap(input logic [1:0] mode, input logic [1:0] pos);
        logic [1:0] res;
        case (mode)
            MODE_NORMAL: res = pos;
            MODE_FIRST:  res = (pos == 2'd1) ? 2'd1 : 2'd2;
            MODE_LAST:   res = (pos == 2'd1) ? 2'd2 : 2'd1;
            default:     res = pos;
        endcase
        return res;
    endfunction

    logic [PIX_W-1:0] v [3][3];
    logic [PIX_W:0]   hs;
    logic [PIX_W:0]   vs;
    logic [PIX_W+1:0] plus;
    logic [PIX_W+1:0] corner;
    logic [PIX_W-1:0] ctr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v[i][j] = i_win[tap(i_sel.row_mode, 2'(i))][tap(i_sel.col_mode, 2'(j))];
            end
        end
    end

    assign hs     = {1'b0, v[1][0]} + {1'b0, v[1][2]};
    assign vs     = {1'b0, v[0][1]} + {1'b0, v[2][1]};
    assign plus   = {1'b0, hs} + {1'b0, vs};
    assign corner = (PIX_W+2)'(v[0][0]) + (PIX_W+2)'(v[0][2])
                  + (PIX_W+2)'(v[2][0]) + (PIX_W+2)'(v[2][2]);
    assign ctr    = v[1][1];

    // G R / B G phase of the output pixel
    always_comb begin
        case ({i_sel.row_odd, i_sel.col_odd})
            2'b00: begin
                o_red   = hs[PIX_W:1];
                o_green = ctr;
                o_blue  = vs[PIX_W:1];
            end
            2'b01: begin
                o_red   = ctr;
                o_green = plus[PIX_W+1:2];
                o_blue  = corner[PIX_W+1:2];
            end
            2'b10: begin
                o_red   = corner[PIX_W+1:2];
                o_green = plus[PIX_W+1:2];
                o_blue  = ctr;
            end
            default: begin
                o_red   = vs[PIX_W:1];
                o_green = ctr;
                o_blue  = hs[PIX_W:1];
            end
        endcase
    end
endmodule

// ===== sv/bayer_bilinear_demosaic.sv =====
// Item path: stage 1 register, then the window register, then the output register per pixel.
// Throughput: 1 item per cycle; row 0 and column 0 items emit nothing, other items 1 pixel,
//   the last column of rows 1 and up emits 2, last-row items past column 0 emit 2 (4 at the
//   frame's last column); pixels leave one per cycle at most, so those hold input ready low longer.
// Reset (synchronous, active low): counters, window, pipeline valids and config registers;
//   the two line-store RAMs are not cleared and need no clearing pass.
module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bbd_pkg::PIX_W-1:0]   i_sample,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bbd_pkg::PIX_W-1:0]   o_red,
    output logic [bbd_pkg::PIX_W-1:0]   o_green,
    output logic [bbd_pkg::PIX_W-1:0]   o_blue,
    output logic                        o_frame_end,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbd_pkg::APB_AW-1:0]  paddr,
    input  logic [bbd_pkg::APB_DW-1:0]  pwdata,
    output logic [bbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_W_BITS) ? CW + 1 : CFG_W_BITS;

    // result slots of one item, in emission order
    localparam int SLOT_PREV_LEFT = 0;
    localparam int SLOT_LAST_LEFT = 1;
    localparam int SLOT_PREV_EDGE = 2;
    localparam int SLOT_LAST_EDGE = 3;

    // ---------------- configuration ----------------
    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // ---------------- position counters ----------------
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [WW-1:0]       width_ext;
    logic [WW-1:0]       width_use;
    logic [CFG_H_BITS-1:0] height_use;
    logic                last_col;
    logic                last_row;
    logic                in_acc;
    logic [3:0]          in_mask;

    always_comb begin
        width_ext = WW'(r_width);
        if (width_ext < WW'(2)) begin
            width_use = WW'(2);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            width_use = WW'(MAX_WIDTH);
        end else begin
            width_use = width_ext;
        end
        if (r_height < CFG_H_BITS'(2)) begin
            height_use = CFG_H_BITS'(2);
        end else if (r_height > CFG_H_BITS'(MAX_HEIGHT)) begin
            height_use = CFG_H_BITS'(MAX_HEIGHT);
        end else begin
            height_use = r_height;
        end
    end

    assign last_col = WW'(r_col) >= (width_use - WW'(1));
    assign last_row = CFG_H_BITS'(r_row) >= (height_use - CFG_H_BITS'(1));
    assign in_acc   = i_valid & o_ready;

    always_comb begin
        in_mask                 = '0;
        in_mask[SLOT_PREV_LEFT] = (r_col != '0) && (r_row != '0);
        in_mask[SLOT_LAST_LEFT] = (r_col != '0) && last_row;
        in_mask[SLOT_PREV_EDGE] = last_col && (r_row != '0);
        in_mask[SLOT_LAST_EDGE] = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- line store: one bank per row parity ----------------
    logic             we0;
    logic             we1;
    logic [PIX_W-1:0] rd0;
    logic [PIX_W-1:0] rd1;

    assign we0 = in_acc & ~r_row[0];
    assign we1 = in_acc &  r_row[0];

    bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_col),
        .i_wdata (i_sample),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd0)
    );

    bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_col),
        .i_wdata (i_sample),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd1)
    );

    // ---------------- stage 1: waits for the line-store read ----------------
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_sample;
    logic             r_s1_bank;
    logic [3:0]       r_s1_mask;
    logic             r_s1_row_is1;
    logic             r_s1_col_is1;
    logic             r_s1_row_odd;
    logic             r_s1_col_odd;
    logic             s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample  <= i_sample;
            r_s1_bank    <= r_row[0];
            r_s1_mask    <= in_mask;
            r_s1_row_is1 <= (r_row == ROW_BITS'(1));
            r_s1_col_is1 <= (r_col == CW'(1));
            r_s1_row_odd <= r_row[0];
            r_s1_col_odd <= r_col[0];
        end
    end

    // ---------------- window and pending pixels of the current item ----------------
    t_win       r_win;
    t_win       n_win;
    logic [3:0] r_b_mask;
    logic [3:0] n_b_mask;
    logic       r_b_row_is1;
    logic       r_b_col_is1;
    logic       r_b_row_odd;
    logic       r_b_col_odd;
    logic [3:0] pick;
    logic       out_free;
    logic       take;
    logic       b_load;

    assign out_free = ~o_valid | i_ready;
    assign pick     = r_b_mask & (~r_b_mask + 4'd1);
    assign take     = out_free & (r_b_mask != '0);
    assign n_b_mask = take ? (r_b_mask & ~pick) : r_b_mask;
    assign s1_adv   = (n_b_mask == '0);
    assign b_load   = r_s1_valid & s1_adv;
    assign o_ready  = ~r_s1_valid | s1_adv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        // row parity picks which bank holds the older line
        n_win[0][2] = r_s1_bank ? rd1 : rd0;
        n_win[1][2] = r_s1_bank ? rd0 : rd1;
        n_win[2][2] = r_s1_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_b_mask <= '0;
        end else if (b_load) begin
            r_win    <= n_win;
            r_b_mask <= r_s1_mask;
        end else begin
            r_b_mask <= n_b_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_row_is1 <= r_s1_row_is1;
            r_b_col_is1 <= r_s1_col_is1;
            r_b_row_odd <= r_s1_row_odd;
            r_b_col_odd <= r_s1_col_odd;
        end
    end

    // ---------------- pixel selection and interpolation ----------------
    t_pix_sel         sel;
    logic             upper_row;
    logic             left_col;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    // upper row = pixel of line r-1; left col = pixel of column c-1
    assign upper_row = pick[SLOT_PREV_LEFT] | pick[SLOT_PREV_EDGE];
    assign left_col  = pick[SLOT_PREV_LEFT] | pick[SLOT_LAST_LEFT];

    always_comb begin
        sel.row_mode = upper_row ? (r_b_row_is1 ? MODE_FIRST : MODE_NORMAL) : MODE_LAST;
        sel.col_mode = left_col  ? (r_b_col_is1 ? MODE_FIRST : MODE_NORMAL) : MODE_LAST;
        sel.row_odd  = upper_row ? ~r_b_row_odd : r_b_row_odd;
        sel.col_odd  = left_col  ? ~r_b_col_odd : r_b_col_odd;
    end

    bbd_interp u_interp (
        .i_win   (r_win),
        .i_sel   (sel),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    // ---------------- output register ----------------
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_red;
    logic [PIX_W-1:0] r_o_green;
    logic [PIX_W-1:0] r_o_blue;
    logic             r_o_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_red       <= red;
            r_o_green     <= green;
            r_o_blue      <= blue;
            r_o_frame_end <= pick[SLOT_LAST_EDGE];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_o_red;
    assign o_green     = r_o_green;
    assign o_blue      = r_o_blue;
    assign o_frame_end = r_o_frame_end;

    // ---------------- assertions ----------------
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item did not reach stage 1");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_sample)))
        else $error("stalled stage 1 item was lost or overwritten");

    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> $onehot({we0, we1}))
        else $error("line store write must hit exactly one bank");

    a_pending_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_b_mask != 4'd0) && !out_free) |=> $stable(r_b_mask))
        else $error("pending pixels changed while output was stalled");

endmodule

// ===== bench/bayer_bilinear_demosaic_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the GRBG bilinear demosaic: streams frames and checks every RGB pixel.
module bayer_bilinear_demosaic_tb;
    import bbd_pkg::*;

    localparam int IDLE_PCT       = 26;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_SAMPLES = 80;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_rgb_pixel;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              i_valid  = 1'b0;
    logic              o_ready;
    logic [PIX_W-1:0]  i_sample = '0;
    logic              o_valid;
    logic              i_ready  = 1'b0;
    logic [PIX_W-1:0]  o_red;
    logic [PIX_W-1:0]  o_green;
    logic [PIX_W-1:0]  o_blue;
    logic              o_frame_end;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state: two stored rows, 3x3 neighborhood, raster position, size registers
    logic [PIX_W-1:0]      line_mem [2][DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      nbhd [3][3];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    t_rgb_pixel            pending_pixels[$];

    bit steady = 1'b0;
    int fail_count     = 0;
    int frames_sent    = 0;
    int samples_sent   = 0;
    int pixels_checked = 0;
    int stall_cycles   = 0;

    bayer_bilinear_demosaic DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // window row/column picked for neighborhood position k under border mirroring
    function automatic int unsigned tap(logic [1:0] mode, int unsigned k);
        case (mode)
            MODE_FIRST: return (k == 0) ? 2 : k;
            MODE_LAST:  return (k == 1) ? 2 : 1;
            default:    return k;
        endcase
    endfunction

    function automatic t_rgb_pixel interpolate(logic [1:0] row_mode, logic [1:0] col_mode,
                                               bit row_odd, bit col_odd);
        int unsigned v[3][3];
        int unsigned hs, vs, plus, corner;
        t_rgb_pixel px;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                v[i][j] = nbhd[tap(row_mode, i)][tap(col_mode, j)];
        hs     = v[1][0] + v[1][2];
        vs     = v[0][1] + v[2][1];
        plus   = hs + vs;
        corner = v[0][0] + v[0][2] + v[2][0] + v[2][2];
        px.frame_end = 1'b0;
        case ({row_odd, col_odd})
            2'b00: begin    // green on a red row
                px.red   = PIX_W'(hs >> 1);
                px.green = PIX_W'(v[1][1]);
                px.blue  = PIX_W'(vs >> 1);
            end
            2'b01: begin    // red site
                px.red   = PIX_W'(v[1][1]);
                px.green = PIX_W'(plus >> 2);
                px.blue  = PIX_W'(corner >> 2);
            end
            2'b10: begin    // blue site
                px.red   = PIX_W'(corner >> 2);
                px.green = PIX_W'(plus >> 2);
                px.blue  = PIX_W'(v[1][1]);
            end
            default: begin  // green on a blue row
                px.red   = PIX_W'(vs >> 1);
                px.green = PIX_W'(v[1][1]);
                px.blue  = PIX_W'(hs >> 1);
            end
        endcase
        return px;
    endfunction

    function automatic void predict_demosaic(logic [PIX_W-1:0] s);
        int unsigned w, h, r, c, bank;
        logic [1:0]  row_mode, col_mode;
        bit          last_col, last_row;
        t_rgb_pixel  px;
        w    = clamp_dim(width_reg, 2, DEF_MAX_WIDTH);
        h    = clamp_dim(height_reg, 2, MAX_HEIGHT);
        r    = row_pos;
        c    = col_pos % DEF_MAX_WIDTH;
        bank = r & 1;
        for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = line_mem[bank][c];
        nbhd[1][2] = line_mem[bank ^ 1][c];
        nbhd[2][2] = s;
        line_mem[bank][c] = s;

        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        row_mode = (r == 1) ? MODE_FIRST : MODE_NORMAL;
        if (c >= 1) begin
            col_mode = (c == 1) ? MODE_FIRST : MODE_NORMAL;
            if (r >= 1)
                pending_pixels.push_back(interpolate(row_mode, col_mode,
                                                     bit'((r - 1) & 1), bit'((c - 1) & 1)));
            // last row flushes its own pixel right after the one above it
            if (last_row)
                pending_pixels.push_back(interpolate(MODE_LAST, col_mode,
                                                     bit'(r & 1), bit'((c - 1) & 1)));
        end
        if (last_col) begin
            if (r >= 1)
                pending_pixels.push_back(interpolate(row_mode, MODE_LAST,
                                                     bit'((r - 1) & 1), bit'(c & 1)));
            if (last_row) begin
                px = interpolate(MODE_LAST, MODE_LAST, bit'(r & 1), bit'(c & 1));
                px.frame_end = 1'b1;
                pending_pixels.push_back(px);
            end
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic void reset_prediction();
        foreach (line_mem[b, k]) line_mem[b][k] = '0;
        foreach (nbhd[i, j]) nbhd[i][j] = '0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = RST_WIDTH;
        height_reg = RST_HEIGHT;
    endfunction

    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_sample(logic [PIX_W-1:0] s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        predict_demosaic(s);
        samples_sent++;
    endtask

    // frame done: drop valid and wait until every pixel of it has come out
    task automatic finish_frame();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        frames_sent++;
    endtask

    task automatic apb_write(logic reg_sel, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_WIDTH)
            width_reg = value[CFG_W_BITS-1:0];
        else
            height_reg = value[CFG_H_BITS-1:0];
        @(posedge i_clk);
    endtask

    task automatic check_register(logic reg_sel);
        logic [APB_DW-1:0] want;
        logic [APB_DW-1:0] mask;
        want = (reg_sel == REG_WIDTH) ? APB_DW'(width_reg) : APB_DW'(height_reg);
        mask = (reg_sel == REG_WIDTH) ? APB_DW'({CFG_W_BITS{1'b1}})
                                      : APB_DW'({CFG_H_BITS{1'b1}});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== want) begin
            $error("%s: expected %0d, actual %0d",
                   (reg_sel == REG_WIDTH) ? "image_width" : "image_height", want, prdata & mask);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [APB_DW-1:0] width_val, logic [APB_DW-1:0] height_val);
        apb_write(REG_WIDTH, width_val);
        apb_write(REG_HEIGHT, height_val);
        check_register(REG_WIDTH);
        check_register(REG_HEIGHT);
    endtask

    task automatic send_frame();
        int unsigned n;
        n = clamp_dim(width_reg, 2, DEF_MAX_WIDTH) * clamp_dim(height_reg, 2, MAX_HEIGHT);
        for (int unsigned k = 0; k < n; k++)
            send_sample(rand_sample());
        finish_frame();
    endtask

    task automatic test_register_reset();
        check_register(REG_WIDTH);
        check_register(REG_HEIGHT);
    endtask

    task automatic test_directed_edges();
        // sizes below range clamp to 2x2, where every pixel is a mirrored border
        configure(0, 1);
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hAA);
        send_sample(8'h55);
        finish_frame();
        // 4x4: interior and both mirrored edges on all four color sites, full-scale sums
        configure(4, 4);
        for (int k = 0; k < 16; k++)
            send_sample((k % 5 == 0) ? 8'h7F : ((k[0] ^ k[2]) ? 8'hFF : 8'h00));
        finish_frame();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        configure(12, 5);
        send_frame();
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int start;
        start = samples_sent;
        while (samples_sent - start < RANDOM_SAMPLES) begin
            configure(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8),
                      ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 5));
            send_frame();
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: red %0d green %0d blue %0d frame_end %0b",
                       o_red, o_green, o_blue, o_frame_end);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (o_red !== want.red) begin
                    $error("red: expected %0d, actual %0d", want.red, o_red);
                    fail_count++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, actual %0d", want.green, o_green);
                    fail_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, actual %0d", want.blue, o_blue);
                    fail_count++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, o_frame_end);
                    fail_count++;
                end
            end
        end
    end

    // cycles in a row with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        reset_prediction();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_directed_edges();
        test_steady_stream();
        test_random_frames();

        $display("Ran %0d frames, %0d samples in, %0d pixels compared.",
                 frames_sent, samples_sent, pixels_checked);
        $display("Sizes from clamped 2x2 up to 12x5, random stalls both sides plus a stall-free frame.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
